FILE: design/icf_pkg.sv
`timescale 1ns / 1ps

package icf_pkg;

    localparam int DATA_CAPACITY = 32768;
    localparam int ADDR_W        = $clog2(DATA_CAPACITY);
    // emit index runs up to capacity plus header and trailer bytes
    localparam int CNT_W         = $clog2(DATA_CAPACITY + 12);

    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_END  = 2'd1;
    localparam logic [1:0] OP_PULL = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_REFUSED = 2'd1;
    localparam logic [1:0] STAT_NOTHING = 2'd2;

    localparam logic [7:0] TAG_0 = 8'd73;
    localparam logic [7:0] TAG_1 = 8'd68;
    localparam logic [7:0] TAG_2 = 8'd65;
    localparam logic [7:0] TAG_3 = 8'd84;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] data_byte;
    } req_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       chunk_last;
        logic [1:0] status;
    } rsp_t;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } ctrl_state_t;

    typedef enum logic [1:0] {
        RS_STATUS,
        RS_PULL,
        RS_RAM
    } res_sel_t;

    typedef struct packed {
        logic       push_en;
        logic       end_short;
        logic       end_stream;
        logic       pull_step;
        logic       pull_read;
        logic       res_load;
        res_sel_t   res_sel;
        logic [1:0] res_status;
    } icf_cmd_t;

    typedef struct packed {
        logic draining;
        logic seen_two;
        logic data_region;
        logic rsp_valid;
    } icf_stat_t;

    // reflected CRC-32, one byte
    function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [7:0] tag_byte(logic [1:0] pos);
        logic [7:0] t;
        case (pos)
            2'd0:    t = TAG_0;
            2'd1:    t = TAG_1;
            2'd2:    t = TAG_2;
            default: t = TAG_3;
        endcase
        return t;
    endfunction

    function automatic logic [7:0] be_byte(logic [31:0] v, logic [1:0] pos);
        logic [7:0] t;
        case (pos)
            2'd0:    t = v[31:24];
            2'd1:    t = v[23:16];
            2'd2:    t = v[15:8];
            default: t = v[7:0];
        endcase
        return t;
    endfunction

    localparam logic [31:0] CRC_SEED =
        crc_byte(crc_byte(crc_byte(crc_byte(32'hFFFF_FFFF, TAG_0), TAG_1), TAG_2), TAG_3);

endpackage

FILE: design/idat_chunk_framer.sv
`timescale 1ns / 1ps

// IDAT chunk framer. Each request beat (push a zlib byte, end of stream, or
// pull one output byte) yields exactly one response beat. Pushed bytes go into
// a DATA_CAPACITY-byte single-port-write buffer while a CRC-32, preset over the
// "IDAT" tag, is updated one byte per push. A chunk closes when the buffer is
// full or at an end after two or more pushes (fewer are dropped); pulls then
// drain length (big-endian), tag, data and CRC (big-endian), with chunk_last on
// the final CRC byte. Push and end are refused while a chunk drains; pull while
// collecting returns "nothing to send". Data bytes pass the buffer's registered
// read port; a request is taken only while no such read is pending and the
// response register is empty or being taken in the same cycle. No clearing pass
// after reset: buffer entries are read only after they are written.

module idat_chunk_framer
    import icf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,

    input  req_t req_data,
    input  logic req_valid,
    output logic req_stall,

    output rsp_t rsp_data,
    output logic rsp_valid,
    input  logic rsp_stall
);

    icf_cmd_t  cmd;
    icf_stat_t st;

    // sequencer: decodes each beat against the framing phase
    icf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_data  (req_data),
        .req_stall (req_stall),
        .rsp_stall (rsp_stall),
        .st        (st),
        .cmd       (cmd)
    );

    // counters, CRC, chunk buffer and response register
    icf_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .st        (st),
        .rsp_data  (rsp_data),
        .rsp_valid (rsp_valid)
    );

endmodule

FILE: design/icf_ram.sv
`timescale 1ns / 1ps

module icf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: design/icf_ctrl.sv
`timescale 1ns / 1ps

module icf_ctrl
    import icf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  req_t        req_data,
    output logic        req_stall,
    input  logic        rsp_stall,
    input  icf_stat_t   st,
    output icf_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;
    logic        accept;

    // output slot must be free (or emptying) before an item is taken
    assign req_stall = (state_reg != ST_IDLE) || (st.rsp_valid && rsp_stall);
    assign accept    = req_valid && !req_stall;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.res_sel    = RS_STATUS;
        cmd.res_status = STAT_OK;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.res_load = 1'b1;
                    case (req_data.operation)
                        OP_PUSH: begin
                            if (st.draining) begin
                                cmd.res_status = STAT_REFUSED;
                            end else begin
                                cmd.push_en = 1'b1;
                            end
                        end
                        OP_END: begin
                            if (st.draining) begin
                                cmd.res_status = STAT_REFUSED;
                            end else if (!st.seen_two) begin
                                cmd.end_short = 1'b1;
                            end else begin
                                cmd.end_stream = 1'b1;
                            end
                        end
                        OP_PULL: begin
                            if (!st.draining) begin
                                cmd.res_status = STAT_NOTHING;
                            end else if (st.data_region) begin
                                // buffer byte: result is loaded from the read port in ST_READ
                                cmd.res_load  = 1'b0;
                                cmd.pull_read = 1'b1;
                                cmd.pull_step = 1'b1;
                                state_next    = ST_READ;
                            end else begin
                                cmd.pull_step = 1'b1;
                                cmd.res_sel   = RS_PULL;
                            end
                        end
                        default: begin
                            cmd.res_status = STAT_NOTHING;
                        end
                    endcase
                end
            end
            ST_READ: begin
                cmd.res_load = 1'b1;
                cmd.res_sel  = RS_RAM;
                state_next   = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: design/icf_datapath.sv
`timescale 1ns / 1ps

module icf_datapath
    import icf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  req_t      req_data,
    input  logic      rsp_stall,
    input  icf_cmd_t  cmd,
    output icf_stat_t st,
    output rsp_t      rsp_data,
    output logic      rsp_valid
);

    logic [CNT_W-1:0]  data_count_reg, data_count_next;
    logic [CNT_W-1:0]  emit_reg, emit_next;
    logic [1:0]        seen_reg, seen_next;
    logic [31:0]       crc_reg, crc_next;
    logic              drain_reg, drain_next;
    logic              ended_reg, ended_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg, rsp_next;

    logic [CNT_W:0]    emit_inc;
    logic [CNT_W:0]    total;
    logic [CNT_W:0]    count_inc;
    logic [CNT_W:0]    data_end;
    logic              is_last;
    logic [CNT_W-1:0]  rel;
    logic [CNT_W-1:0]  crc_pos;
    logic [7:0]        pull_byte;
    logic [7:0]        ram_rdata;

    assign emit_inc  = {1'b0, emit_reg} + (CNT_W+1)'(1);
    assign total     = {1'b0, data_count_reg} + (CNT_W+1)'(12);
    assign data_end  = {1'b0, data_count_reg} + (CNT_W+1)'(8);
    assign count_inc = {1'b0, data_count_reg} + (CNT_W+1)'(1);
    assign is_last   = emit_inc >= total;
    assign rel       = emit_reg - CNT_W'(8);
    assign crc_pos   = emit_reg - data_count_reg;

    assign st.draining    = drain_reg;
    assign st.seen_two    = (seen_reg == 2'd2);
    assign st.data_region = (emit_reg >= CNT_W'(8)) && ({1'b0, emit_reg} < data_end);
    assign st.rsp_valid   = rsp_valid_reg;

    icf_ram #(
        .WIDTH (8),
        .DEPTH (DATA_CAPACITY)
    ) u_buf (
        .clk   (clk),
        .we    (cmd.push_en),
        .waddr (data_count_reg[ADDR_W-1:0]),
        .wdata (req_data.data_byte),
        .re    (cmd.pull_read),
        .raddr (rel[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // header, tag or trailer byte at the current emit index
    always_comb begin
        if (emit_reg < CNT_W'(4)) begin
            pull_byte = be_byte(32'(data_count_reg), emit_reg[1:0]);
        end else if (emit_reg < CNT_W'(8)) begin
            pull_byte = tag_byte(emit_reg[1:0]);
        end else begin
            pull_byte = be_byte(~crc_reg, crc_pos[1:0]);
        end
    end

    always_comb begin
        data_count_next = data_count_reg;
        emit_next       = emit_reg;
        seen_next       = seen_reg;
        crc_next        = crc_reg;
        drain_next      = drain_reg;
        ended_next      = ended_reg;

        if (cmd.push_en) begin
            data_count_next = count_inc[CNT_W-1:0];
            crc_next        = crc_byte(crc_reg, req_data.data_byte);
            if (seen_reg != 2'd2) begin
                seen_next = seen_reg + 2'd1;
            end
            if (count_inc == (CNT_W+1)'(DATA_CAPACITY)) begin
                drain_next = 1'b1;
                emit_next  = '0;
            end
        end

        if (cmd.end_stream) begin
            ended_next = 1'b1;
            drain_next = 1'b1;
            emit_next  = '0;
        end

        if (cmd.pull_step) begin
            if (is_last) begin
                data_count_next = '0;
                crc_next        = CRC_SEED;
                drain_next      = 1'b0;
                emit_next       = '0;
                if (ended_reg) begin
                    seen_next  = 2'd0;
                    ended_next = 1'b0;
                end
            end else begin
                emit_next = emit_inc[CNT_W-1:0];
            end
        end

        if (cmd.end_short) begin
            data_count_next = '0;
            crc_next        = CRC_SEED;
            drain_next      = 1'b0;
            emit_next       = '0;
            seen_next       = 2'd0;
            ended_next      = 1'b0;
        end
    end

    always_comb begin
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        if (cmd.res_load) begin
            rsp_valid_next = 1'b1;
            case (cmd.res_sel)
                RS_PULL: begin
                    rsp_next.out_byte   = pull_byte;
                    rsp_next.out_valid  = 1'b1;
                    rsp_next.chunk_last = is_last;
                    rsp_next.status     = STAT_OK;
                end
                RS_RAM: begin
                    rsp_next.out_byte   = ram_rdata;
                    rsp_next.out_valid  = 1'b1;
                    rsp_next.chunk_last = 1'b0;
                    rsp_next.status     = STAT_OK;
                end
                default: begin
                    rsp_next.out_byte   = 8'd0;
                    rsp_next.out_valid  = 1'b0;
                    rsp_next.chunk_last = 1'b0;
                    rsp_next.status     = cmd.res_status;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            data_count_reg <= '0;
            emit_reg       <= '0;
            seen_reg       <= 2'd0;
            crc_reg        <= CRC_SEED;
            drain_reg      <= 1'b0;
            ended_reg      <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end else begin
            data_count_reg <= data_count_next;
            emit_reg       <= emit_next;
            seen_reg       <= seen_next;
            crc_reg        <= crc_next;
            drain_reg      <= drain_next;
            ended_reg      <= ended_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        rsp_reg <= rsp_next;
    end

    assign rsp_data  = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

endmodule

FILE: design/icf_checker.sv
`timescale 1ns / 1ps

module icf_checker
    import icf_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input req_t req_data,
    input logic req_valid,
    input logic req_stall,
    input rsp_t rsp_data,
    input logic rsp_valid,
    input logic rsp_stall
);

    // stalled request beat holds
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_stall |=> req_valid && $stable(req_data))
        else $error("request beat changed under stall");

    // stalled response beat holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
        else $error("response beat changed under stall");

    a_last_is_byte: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.chunk_last |-> rsp_data.out_valid &&
            (rsp_data.status == STAT_OK))
        else $error("chunk_last without a delivered byte");

    a_no_byte_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.out_valid |->
            (rsp_data.out_byte == 8'd0) && !rsp_data.chunk_last)
        else $error("stray byte on non-pull response");

    a_refused_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.status != STAT_OK) |-> !rsp_data.out_valid)
        else $error("byte delivered with error status");

endmodule

bind idat_chunk_framer icf_checker u_icf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_data  (req_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_data  (rsp_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall)
);
